>>> src/lbc_pkg.sv
// shared types, codes and constants for the led blink code generator
package lbc_pkg;

	localparam int unsigned LedMax      = 10;
	localparam int unsigned LedCount    = 10;
	localparam int unsigned ModeW       = 3;
	localparam int unsigned CountW      = 16;
	localparam int unsigned PhaseW      = 2;
	localparam int unsigned CfgIdxW     = 2;
	localparam int unsigned CfgDataW    = 30;
	localparam int unsigned ModesW      = LedMax * ModeW;

	// register indexes
	localparam logic [CfgIdxW-1:0] RegInterval = 2'd0;
	localparam logic [CfgIdxW-1:0] RegPulse    = 2'd1;
	localparam logic [CfgIdxW-1:0] RegModes    = 2'd2;
	localparam logic [CfgIdxW-1:0] RegPresent  = 2'd3;

	// reset values
	localparam logic [CountW-1:0] IntervalReset = 16'd1000;
	localparam logic [CountW-1:0] PulseReset    = 16'd250;
	localparam logic [LedMax-1:0] PresentReset  = {LedMax{1'b1}};
	localparam logic [CountW-1:0] CountMax      = {CountW{1'b1}};

	// led mode codes
	localparam logic [ModeW-1:0] ModeOff    = 3'd0;
	localparam logic [ModeW-1:0] ModeOn     = 3'd1;
	localparam logic [ModeW-1:0] ModeLong   = 3'd2;
	localparam logic [ModeW-1:0] ModeBlink1 = 3'd3;
	localparam logic [ModeW-1:0] ModeBlink2 = 3'd4;
	localparam logic [ModeW-1:0] ModeBlink3 = 3'd5;
	localparam logic [ModeW-1:0] ModeBlink4 = 3'd6;
	localparam logic [ModeW-1:0] ModeUnused = 3'd7;

	// long blink stays lit below this phase
	localparam logic [PhaseW-1:0] LongPhaseLimit = 2'd3;

	typedef struct packed {
		logic              pulse;
		logic [PhaseW-1:0] phase;
	} lbc_blink_t;

	typedef struct packed {
		logic [LedMax-1:0] pattern;
		logic              changed;
		lbc_blink_t        blink;
	} lbc_result_t;

endpackage

>>> src/led_blink_code_generator.sv
// top level of the led blink code generator
// an accepted beat's result is registered into the output register, or into the skid entry while the output stalls
// throughput: one beat per cycle while in_stall is low; the timer, phase and led decode update in one pass
// a two-entry output stage (output register plus skid) keeps input open while a result waits
// reset: asynchronous, active low; timer, pulse, phase and leds clear, registers take defaults
// (interval 1000, pulse 250, all modes off, all leds fitted); output stage empties
module led_blink_code_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [lbc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [lbc_pkg::CfgDataW-1:0]  cfg_data,
	// input channel: one beat per millisecond tick or query
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          advance_ms,
	// output channel: one result beat per input beat
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lbc_pkg::LedMax-1:0]    led_pattern,
	output logic                          phase_changed,
	output logic [lbc_pkg::PhaseW-1:0]    blink_phase,
	output logic                          pulse_active
);

	// configuration registers
	logic [lbc_pkg::CountW-1:0] interval_q;
	logic [lbc_pkg::CountW-1:0] pulse_len_q;
	logic [lbc_pkg::ModesW-1:0] modes_q;
	logic [lbc_pkg::LedMax-1:0] present_q;

	// timer state
	logic [lbc_pkg::CountW-1:0] elapsed_q;
	lbc_pkg::lbc_blink_t        blink_q;
	logic [lbc_pkg::LedMax-1:0] drive_q;

	// output stage
	lbc_pkg::lbc_result_t out_q;
	lbc_pkg::lbc_result_t skid_q;
	logic                 out_valid_q;
	logic                 skid_valid_q;

	logic                       accept;
	logic                       out_free;
	logic [lbc_pkg::CountW-1:0] elapsed_inc;
	logic [lbc_pkg::CountW-1:0] elapsed_nxt;
	lbc_pkg::lbc_blink_t        blink_nxt;
	logic                       changed;
	logic [lbc_pkg::LedMax-1:0] decoded;
	logic [lbc_pkg::LedMax-1:0] drive_nxt;
	lbc_pkg::lbc_result_t       result;

	// input is held off only once the skid entry is occupied
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= lbc_pkg::IntervalReset;
			pulse_len_q <= lbc_pkg::PulseReset;
			modes_q     <= '0;
			present_q   <= lbc_pkg::PresentReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbc_pkg::RegInterval: interval_q  <= cfg_data[lbc_pkg::CountW-1:0];
				lbc_pkg::RegPulse:    pulse_len_q <= cfg_data[lbc_pkg::CountW-1:0];
				lbc_pkg::RegModes:    modes_q     <= cfg_data[lbc_pkg::ModesW-1:0];
				lbc_pkg::RegPresent:  present_q   <= cfg_data[lbc_pkg::LedMax-1:0];
				default: ;
			endcase
		end
	end

	// saturating millisecond count, then the pulse on/off decision
	always_comb begin
		elapsed_inc = elapsed_q;
		if (advance_ms && (elapsed_q != lbc_pkg::CountMax)) begin
			elapsed_inc = elapsed_q + 1'b1;
		end
		elapsed_nxt = elapsed_inc;
		blink_nxt   = blink_q;
		changed     = 1'b0;
		if (blink_q.pulse && (elapsed_inc >= pulse_len_q)) begin
			// pulse ends, phase steps on with wrap
			blink_nxt.pulse = 1'b0;
			blink_nxt.phase = blink_q.phase + 1'b1;
			elapsed_nxt     = '0;
			changed         = 1'b1;
		end else if (!blink_q.pulse && (elapsed_inc >= interval_q)) begin
			blink_nxt.pulse = 1'b1;
			elapsed_nxt     = '0;
			changed         = 1'b1;
		end
	end

	lbc_drive u_drive (
		.modes   (modes_q),
		.present (present_q),
		.blink   (blink_nxt),
		.pattern (decoded)
	);

	// led levels are held between changes
	assign drive_nxt = changed ? decoded : drive_q;

	always_comb begin
		result.pattern = drive_nxt;
		result.changed = changed;
		result.blink   = blink_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			blink_q   <= '0;
			drive_q   <= '0;
		end else if (accept) begin
			elapsed_q <= elapsed_nxt;
			blink_q   <= blink_nxt;
			drive_q   <= drive_nxt;
		end
	end

	// output register with skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept;
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			skid_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign led_pattern   = out_q.pattern;
	assign phase_changed = out_q.changed;
	assign blink_phase   = out_q.blink.phase;
	assign pulse_active  = out_q.blink.pulse;

endmodule

>>> src/lbc_drive.sv
// per-led lit decode from mode, presence and blink state
module lbc_drive (
	input  logic [lbc_pkg::ModesW-1:0] modes,
	input  logic [lbc_pkg::LedMax-1:0] present,
	input  lbc_pkg::lbc_blink_t        blink,
	output logic [lbc_pkg::LedMax-1:0] pattern
);

	always_comb begin
		logic [lbc_pkg::ModeW-1:0] mode;
		logic                      lit;
		pattern = '0;
		for (int unsigned i = 0; i < lbc_pkg::LedMax; i++) begin
			mode = modes[i*lbc_pkg::ModeW +: lbc_pkg::ModeW];
			case (mode)
				lbc_pkg::ModeOn:     lit = 1'b1;
				lbc_pkg::ModeLong:   lit = (blink.phase < lbc_pkg::LongPhaseLimit);
				lbc_pkg::ModeBlink1: lit = blink.pulse && (blink.phase < 2'd1);
				lbc_pkg::ModeBlink2: lit = blink.pulse && (blink.phase < 2'd2);
				lbc_pkg::ModeBlink3: lit = blink.pulse && (blink.phase < 2'd3);
				lbc_pkg::ModeBlink4: lit = blink.pulse;
				default:             lit = 1'b0;
			endcase
			// leds beyond the fitted count stay low
			pattern[i] = lit && present[i] && (i < lbc_pkg::LedCount);
		end
	end

endmodule

>>> src/lbc_checker.sv
// port-level checker for the led blink code generator, with its bind
module lbc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [lbc_pkg::LedMax-1:0]  led_pattern,
	input logic                        phase_changed,
	input logic [lbc_pkg::PhaseW-1:0]  blink_phase,
	input logic                        pulse_active
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(led_pattern)
			&& $stable(phase_changed) && $stable(blink_phase) && $stable(pulse_active))
	else $error("stalled result beat changed");

	// input is only held off while a result is waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
	else $error("input stalled with empty output");

	// an accepted beat into an empty output shows up next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> out_valid)
	else $error("accepted beat did not reach output");

	// no result appears without an accepted beat behind it
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall))
	else $error("result beat without input beat");

endmodule

bind led_blink_code_generator lbc_checker u_lbc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.led_pattern   (led_pattern),
	.phase_changed (phase_changed),
	.blink_phase   (blink_phase),
	.pulse_active  (pulse_active)
);

>>> dv/tb_top.sv
// self-checking testbench for the led blink code generator
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned CycleLimit   = 200_000;
	localparam int unsigned SettleCycles = 4;
	localparam int unsigned TailCycles   = 8;
	localparam int unsigned HoldCycles   = 200;
	localparam int unsigned LongBeats    = 40;
	localparam int unsigned RandPhases   = 10;
	localparam int unsigned PhaseBeats   = 115;
	localparam int unsigned HoldPhase    = 2;
	localparam int unsigned PlanRows     = 35;

	// every mode at least once, led 9 in the top bits
	localparam logic [lbc_pkg::CfgDataW-1:0] MixedModes = {lbc_pkg::ModeLong, lbc_pkg::ModeOn,
		lbc_pkg::ModeOff, lbc_pkg::ModeUnused, lbc_pkg::ModeBlink4, lbc_pkg::ModeBlink3,
		lbc_pkg::ModeBlink2, lbc_pkg::ModeBlink1, lbc_pkg::ModeLong, lbc_pkg::ModeOn};
	localparam logic [lbc_pkg::CfgDataW-1:0] AllUnused  =
		{lbc_pkg::LedMax{lbc_pkg::ModeUnused}};
	localparam logic [lbc_pkg::CfgDataW-1:0] AllOn      = {lbc_pkg::LedMax{lbc_pkg::ModeOn}};

	typedef enum logic {RowBeat, RowWrite} row_kind_t;

	typedef struct packed {
		row_kind_t                     kind;
		logic [lbc_pkg::CfgIdxW-1:0]   idx;
		logic [lbc_pkg::CfgDataW-1:0]  data;
		logic                          adv;
		logic                          typed;
		lbc_pkg::lbc_result_t          want;
	} plan_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [lbc_pkg::CfgIdxW-1:0]   cfg_index;
	logic [lbc_pkg::CfgDataW-1:0]  cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic                          advance_ms;
	logic                          out_valid;
	logic                          out_stall;
	logic [lbc_pkg::LedMax-1:0]    led_pattern;
	logic                          phase_changed;
	logic [lbc_pkg::PhaseW-1:0]    blink_phase;
	logic                          pulse_active;

	// blink timer copy: registers and state
	logic [lbc_pkg::CountW-1:0]    interval_len;
	logic [lbc_pkg::CountW-1:0]    pulse_len;
	logic [lbc_pkg::CfgDataW-1:0]  mode_bits;
	logic [lbc_pkg::LedMax-1:0]    fitted_mask;
	logic [lbc_pkg::CountW-1:0]    tick_count;
	logic                          pulse_on;
	logic [lbc_pkg::PhaseW-1:0]    phase_q;
	logic [lbc_pkg::LedMax-1:0]    drive_q;

	lbc_pkg::lbc_result_t          blink_q[$];
	lbc_pkg::lbc_result_t          got_want;
	plan_row_t                     plan [PlanRows];
	int unsigned                   mismatches = 0;
	int unsigned                   cycle_count = 0;
	bit                            gaps_on = 1'b1;
	bit                            stalls_on = 1'b1;
	bit                            hold_req = 1'b0;

	led_blink_code_generator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.advance_ms    (advance_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.led_pattern   (led_pattern),
		.phase_changed (phase_changed),
		.blink_phase   (blink_phase),
		.pulse_active  (pulse_active)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// is one led lit for its mode at the current pulse and phase
	function automatic logic led_lit(input logic [lbc_pkg::ModeW-1:0] mode);
		case (mode) inside
			lbc_pkg::ModeOn:   return 1'b1;
			lbc_pkg::ModeLong: return phase_q < lbc_pkg::LongPhaseLimit;
			lbc_pkg::ModeBlink1, lbc_pkg::ModeBlink2, lbc_pkg::ModeBlink3, lbc_pkg::ModeBlink4:
				return pulse_on && ({1'b0, phase_q} < (mode - lbc_pkg::ModeLong));
			default:  return 1'b0;
		endcase
	endfunction

	// advance the timer by one beat and return the result it shows
	function automatic lbc_pkg::lbc_result_t blink_step(input logic adv);
		lbc_pkg::lbc_result_t r;
		logic moved;
		moved = 1'b0;
		if (adv && tick_count != lbc_pkg::CountMax)
			tick_count = tick_count + 1'b1;
		if (pulse_on && tick_count >= pulse_len) begin
			pulse_on   = 1'b0;
			tick_count = '0;
			phase_q    = phase_q + 1'b1;
			moved      = 1'b1;
		end else if (!pulse_on && tick_count >= interval_len) begin
			pulse_on   = 1'b1;
			tick_count = '0;
			moved      = 1'b1;
		end
		// drive levels only change when the pulse or phase moves
		if (moved)
			for (int i = 0; i < lbc_pkg::LedCount; i++)
				drive_q[i] = fitted_mask[i]
					&& led_lit(mode_bits[lbc_pkg::ModeW*i +: lbc_pkg::ModeW]);
		r.pattern     = drive_q;
		r.changed     = moved;
		r.blink.pulse = pulse_on;
		r.blink.phase = phase_q;
		return r;
	endfunction

	function automatic logic [lbc_pkg::CountW-1:0] draw_len();
		if ($urandom_range(0, 3) == 0)
			return lbc_pkg::CountW'($urandom_range(0, 60));
		return lbc_pkg::CountW'($urandom_range(0, 6));
	endfunction

	// offer one beat; the expectation is queued at the edge that takes it
	task automatic drive_beat(input logic adv, input logic typed,
		input lbc_pkg::lbc_result_t want);
		int unsigned gap;
		lbc_pkg::lbc_result_t r;
		gap = gaps_on ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		advance_ms <= adv;
		do @(posedge clk); while (in_stall);
		r = blink_step(adv);
		blink_q.push_back(typed ? want : r);
	endtask

	// registers only change once every result is out
	task automatic settle();
		in_valid <= 1'b0;
		while (blink_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lbc_pkg::CfgIdxW-1:0] idx,
		input logic [lbc_pkg::CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			lbc_pkg::RegInterval: interval_len = data[lbc_pkg::CountW-1:0];
			lbc_pkg::RegPulse:    pulse_len    = data[lbc_pkg::CountW-1:0];
			lbc_pkg::RegModes:    mode_bits    = data;
			lbc_pkg::RegPresent:  fitted_mask  = data[lbc_pkg::LedMax-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: a random stall before each beat, or one long hold-off on request
	initial begin
		int unsigned k;
		out_stall = 1'b0;
		forever begin
			if (hold_req)
				k = HoldCycles;
			else
				k = stalls_on ? $urandom_range(0, 16) : 0;
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// result check against the oldest pending expectation
	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid && !out_stall) begin
			if (blink_q.size() == 0) begin
				$error("unexpected result beat: led_pattern %h", led_pattern);
				mismatches++;
			end else begin
				got_want = blink_q.pop_front();
				if (led_pattern !== got_want.pattern) begin
					$error("led_pattern: expected %h, got %h", got_want.pattern, led_pattern);
					mismatches++;
				end
				if (phase_changed !== got_want.changed) begin
					$error("phase_changed: expected %b, got %b", got_want.changed,
						phase_changed);
					mismatches++;
				end
				if (blink_phase !== got_want.blink.phase) begin
					$error("blink_phase: expected %d, got %d", got_want.blink.phase,
						blink_phase);
					mismatches++;
				end
				if (pulse_active !== got_want.blink.pulse) begin
					$error("pulse_active: expected %b, got %b", got_want.blink.pulse,
						pulse_active);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("led_blink_code_generator verification failed");
			$finish;
		end
	end

	initial begin
		logic [13:0] pad;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = lbc_pkg::RegInterval;
		cfg_data   = '0;
		in_valid   = 1'b0;
		advance_ms = 1'b0;

		interval_len = lbc_pkg::IntervalReset;
		pulse_len    = lbc_pkg::PulseReset;
		mode_bits    = '0;
		fitted_mask  = lbc_pkg::PresentReset;
		tick_count   = '0;
		pulse_on     = 1'b0;
		phase_q      = '0;
		drive_q      = '0;

		plan = '{
			// reset state: a query and a first tick change nothing
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b0, 1'b1, '{'0, 1'b0, '{1'b0, 2'd0}}},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b1, '{'0, 1'b0, '{1'b0, 2'd0}}},
			'{RowWrite, lbc_pkg::RegModes,    MixedModes, 1'b0, 1'b0, '0},
			'{RowWrite, lbc_pkg::RegInterval, 30'd1, 1'b0, 1'b0, '0},
			'{RowWrite, lbc_pkg::RegPulse,    30'd2, 1'b0, 1'b0, '0},
			// walk all four phases
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b0, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b0, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			// pulse length lowered to the count: the change lands on a query
			'{RowWrite, lbc_pkg::RegPulse,    30'd1, 1'b0, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b0, 1'b0, '0},
			// presence change holds the old drive until the next change
			'{RowWrite, lbc_pkg::RegPresent,  30'h155, 1'b0, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b0, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			// zero lengths: pulse toggles on every beat, queries included
			'{RowWrite, lbc_pkg::RegInterval, '0, 1'b0, 1'b0, '0},
			'{RowWrite, lbc_pkg::RegPulse,    '0, 1'b0, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b0, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b0, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			// unused code on every led, all fitted
			'{RowWrite, lbc_pkg::RegModes,    AllUnused, 1'b0, 1'b0, '0},
			'{RowWrite, lbc_pkg::RegPresent,  {lbc_pkg::CfgDataW{1'b1}}, 1'b0, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			// every led on but none fitted
			'{RowWrite, lbc_pkg::RegModes,    AllOn, 1'b0, 1'b0, '0},
			'{RowWrite, lbc_pkg::RegPresent,  '0, 1'b0, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0},
			'{RowBeat,  lbc_pkg::RegInterval, '0, 1'b1, 1'b0, '0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == RowWrite) begin
				settle();
				write_reg(plan[r].idx, plan[r].data);
			end else
				drive_beat(plan[r].adv, plan[r].typed, plan[r].want);
		end

		// longest lengths, run back to back with the full-width compare in play
		settle();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		write_reg(lbc_pkg::RegModes, lbc_pkg::CfgDataW'($urandom_range(0, 32'h3FFF_FFFF)));
		write_reg(lbc_pkg::RegPresent, lbc_pkg::PresentReset);
		write_reg(lbc_pkg::RegInterval, {lbc_pkg::CfgDataW{1'b1}});
		write_reg(lbc_pkg::RegPulse, 30'd1);
		repeat (LongBeats) drive_beat(1'b1, 1'b0, '0);
		settle();
		pad = 14'($urandom);
		write_reg(lbc_pkg::RegInterval, 30'd1);
		write_reg(lbc_pkg::RegPulse, {pad, lbc_pkg::CountMax});
		repeat (LongBeats) drive_beat(1'b1, 1'b0, '0);

		for (int ph = 0; ph < RandPhases; ph++) begin
			settle();
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			// one phase where the output holds off and the input backs up
			if (ph == HoldPhase) begin
				gaps_on  = 1'b0;
				hold_req = 1'b1;
			end
			pad = 14'($urandom);
			if ($urandom_range(0, 1))
				write_reg(lbc_pkg::RegInterval, {pad, draw_len()});
			pad = 14'($urandom);
			if ($urandom_range(0, 1))
				write_reg(lbc_pkg::RegPulse, {pad, draw_len()});
			if ($urandom_range(0, 2) != 0)
				write_reg(lbc_pkg::RegModes,
					lbc_pkg::CfgDataW'($urandom_range(0, 32'h3FFF_FFFF)));
			if ($urandom_range(0, 2) == 0)
				write_reg(lbc_pkg::RegPresent, lbc_pkg::CfgDataW'($urandom));
			else if ($urandom_range(0, 2) == 0)
				write_reg(lbc_pkg::RegPresent, lbc_pkg::PresentReset);
			repeat (PhaseBeats) drive_beat($urandom_range(0, 3) != 0, 1'b0, '0);
		end

		in_valid <= 1'b0;
		while (blink_q.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0)
			$display("led_blink_code_generator verification clean");
		else
			$display("led_blink_code_generator verification failed");
		$finish;
	end

endmodule
